// ===== sv/cvr_pkg.sv =====
// ----------------------------------------------------------------------------
// cvr_pkg
// Shared types, constants and fixed-point helpers of the convolution reverb.
// ----------------------------------------------------------------------------
package cvr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 24;
    localparam int OPA_W    = 41;
    localparam int OPB_W    = 18;
    localparam int PROD_W   = OPA_W + OPB_W;
    // Largest sum is an FIR over 4096 taps of 40-bit products: 52 bits.
    localparam int ACC_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [16:0] DAMP_ONE = 17'd32768;
    localparam logic signed [OPB_W-1:0] FB_SCALE = 18'sd4915;

    localparam logic signed [ACC_W-1:0] SAT24_MAX = ACC_W'(64'sd8388607);
    localparam logic signed [ACC_W-1:0] SAT24_MIN = ACC_W'(-64'sd8388608);
    localparam logic signed [ACC_W-1:0] SAT16_MAX = ACC_W'(64'sd32767);
    localparam logic signed [ACC_W-1:0] SAT16_MIN = ACC_W'(-64'sd32768);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERB_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IR_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN = 3'd5;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_STALE,
        ST_STALE_W,
        ST_SUM,
        ST_DAMP_A,
        ST_DAMP_B,
        ST_DAMP_W,
        ST_DSTORE,
        ST_ECHO_ADR,
        ST_ECHO_MUL,
        ST_ECHO_W,
        ST_ECHO_ADD,
        ST_SLOT_WR,
        ST_FIR_RUN,
        ST_FIR_DRAIN,
        ST_YSET,
        ST_FB_A,
        ST_FB_AW,
        ST_FB_B,
        ST_FB_BW,
        ST_FB_SET,
        ST_OUT_L,
        ST_OUT_LW,
        ST_OUT_R,
        ST_OUT_RW,
        ST_OUT_DONE
    } state_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_op_t;

    // Round half up: add half an LSB, then arithmetic shift
    function automatic logic signed [ACC_W-1:0] rnd(
        input logic signed [ACC_W-1:0] v,
        input int                      sh
    );
        logic signed [ACC_W-1:0] half;
        half = '0;
        half[sh-1] = 1'b1;
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v;
        if (v > SAT24_MAX) t = SAT24_MAX;
        if (v < SAT24_MIN) t = SAT24_MIN;
        return t[DATA_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v;
        if (v > SAT16_MAX) t = SAT16_MAX;
        if (v < SAT16_MIN) t = SAT16_MIN;
        return t[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== sv/convolution_reverb_fir_core.sv =====
// Sequence: an audio word runs the feedback sum, damping, one echo pass per echo tap
// with reverb enabled, the FIR over ir_length taps (capped at MAX_TAPS), feedback and gains.
// A new audio word is taken only once the last one has been handed to the output;
// a coefficient load is written from the idle state. A held result stalls the sequencer.
// Reset: a clearing pass zeroes the delay line and coefficient table;
// no request is taken during it.
// ----------------------------------------------------------------------------
// convolution_reverb_fir_core
// Mono convolution reverb with damping, multitap feedback and stereo gains.
// ----------------------------------------------------------------------------
module convolution_reverb_fir_core #(
    parameter int BUFFER_DEPTH = 32768,
    parameter int MAX_TAPS     = 4096,
    parameter int REVERB_TAPS  = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cvr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                req_type,
    input  logic signed [15:0]                  left_in,
    input  logic signed [15:0]                  right_in,
    input  logic [11:0]                         coef_index,
    input  logic signed [15:0]                  coef_value,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [15:0]                  left_out,
    output logic signed [15:0]                  right_out
);

    localparam int BW    = $clog2(BUFFER_DEPTH);
    localparam int CW    = $clog2(MAX_TAPS);
    localparam int LW    = $clog2(MAX_TAPS + 1);
    localparam int JW    = $clog2(REVERB_TAPS + 1);
    localparam int CLR_N = (BUFFER_DEPTH > MAX_TAPS) ? BUFFER_DEPTH : MAX_TAPS;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int DW    = cvr_pkg::DATA_W;
    localparam int AW    = cvr_pkg::ACC_W;

    // Configuration registers
    logic [15:0]        damp_gain_reg;
    logic signed [15:0] fb_gain_reg;
    logic               reverb_en_reg;
    logic [12:0]        ir_length_reg;
    logic [15:0]        left_gain_reg;
    logic [15:0]        right_gain_reg;

    cvr_pkg::state_t    state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [BW-1:0]      pos_reg, pos_next;
    logic [BW-1:0]      xi_reg, xi_next;
    logic [LW-1:0]      lm_reg, lm_next;
    logic [LW-1:0]      im_reg, im_next;
    logic [LW-1:0]      tap_reg, tap_next;
    logic [JW-1:0]      echo_reg, echo_next;
    logic               drain_reg, drain_next;
    logic               fir_vld_reg;
    logic signed [15:0] lin_reg, lin_next;
    logic signed [15:0] rin_reg, rin_next;
    logic signed [DW-1:0] sum_reg, sum_next;
    logic signed [DW-1:0] damp_reg, damp_next;
    logic signed [DW-1:0] fbst_reg, fbst_next;
    logic signed [DW-1:0] slot_reg, slot_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic signed [15:0] lres_reg, lres_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic signed [15:0] lout_reg, lout_next;
    logic signed [15:0] rout_reg, rout_next;

    logic [LW-1:0]      len;
    logic [16:0]        damp_a;
    logic               req_fire;
    logic               cfg_fire;
    logic [BW-1:0]      xi_dec;

    // Delay line and coefficient memory ports
    logic               dl_we;
    logic [BW-1:0]      dl_waddr;
    logic [DW-1:0]      dl_wdata;
    logic [BW-1:0]      dl_raddr;
    logic [DW-1:0]      dl_rdata;
    logic               cf_we;
    logic [CW-1:0]      cf_waddr;
    logic [15:0]        cf_wdata;
    logic [15:0]        cf_rdata;

    cvr_pkg::mac_op_t                 mac_op;
    logic signed [cvr_pkg::OPA_W-1:0] mac_a;
    logic signed [cvr_pkg::OPB_W-1:0] mac_b;
    logic signed [AW-1:0]             acc;

    // Step back d positions, modulo the buffer depth
    function automatic logic [BW-1:0] back(input logic [BW-1:0] p, input logic [BW-1:0] d);
        logic [BW:0] diff;
        diff = {1'b0, p} - {1'b0, d};
        if (diff[BW])
        begin
            diff = diff + (BW+1)'(BUFFER_DEPTH);
        end
        return diff[BW-1:0];
    endfunction

    cvr_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(DW)) u_delay (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    cvr_ram #(.DEPTH(MAX_TAPS), .WIDTH(16)) u_coef (
        .clk   (clk),
        .we    (cf_we),
        .waddr (cf_waddr),
        .wdata (cf_wdata),
        .raddr (tap_reg[CW-1:0]),
        .rdata (cf_rdata)
    );

    cvr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .opa   (mac_a),
        .opb   (mac_b),
        .acc   (acc)
    );

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign req_ready = (state_reg == cvr_pkg::ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign left_out  = lout_reg;
    assign right_out = rout_reg;

    // Clamp tap count and damping weight
    assign len    = (32'(ir_length_reg) > 32'(MAX_TAPS)) ? LW'(MAX_TAPS) : LW'(ir_length_reg);
    assign damp_a = (damp_gain_reg > 16'd32768) ? cvr_pkg::DAMP_ONE : 17'(damp_gain_reg);
    assign xi_dec = (xi_reg == '0) ? BW'(BUFFER_DEPTH - 1) : xi_reg - BW'(1);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_gain_reg  <= 16'd25033;
            fb_gain_reg    <= '0;
            reverb_en_reg  <= 1'b0;
            ir_length_reg  <= 13'd1024;
            left_gain_reg  <= 16'd1024;
            right_gain_reg <= 16'd1024;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                cvr_pkg::CFG_DAMP_GAIN:  damp_gain_reg  <= cfg_data;
                cvr_pkg::CFG_FB_GAIN:    fb_gain_reg    <= signed'(cfg_data);
                cvr_pkg::CFG_REVERB_EN:  reverb_en_reg  <= cfg_data[0];
                cvr_pkg::CFG_IR_LENGTH:  ir_length_reg  <= cfg_data[12:0];
                cvr_pkg::CFG_LEFT_GAIN:  left_gain_reg  <= cfg_data;
                cvr_pkg::CFG_RIGHT_GAIN: right_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvr_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            damp_reg      <= '0;
            fbst_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            fir_vld_reg   <= 1'b0;
            drain_reg     <= 1'b0;
            tap_reg       <= '0;
            echo_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pos_reg       <= pos_next;
            damp_reg      <= damp_next;
            fbst_reg      <= fbst_next;
            rsp_valid_reg <= rsp_valid_next;
            fir_vld_reg   <= (state_reg == cvr_pkg::ST_FIR_RUN);
            drain_reg     <= drain_next;
            tap_reg       <= tap_next;
            echo_reg      <= echo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xi_reg   <= xi_next;
        lm_reg   <= lm_next;
        im_reg   <= im_next;
        lin_reg  <= lin_next;
        rin_reg  <= rin_next;
        sum_reg  <= sum_next;
        slot_reg <= slot_next;
        y_reg    <= y_next;
        lres_reg <= lres_next;
        lout_reg <= lout_next;
        rout_reg <= rout_next;
    end

    // Next state, memory ports and multiplier operands
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pos_next       = pos_reg;
        xi_next        = xi_reg;
        lm_next        = lm_reg;
        im_next        = im_reg;
        tap_next       = tap_reg;
        echo_next      = echo_reg;
        drain_next     = drain_reg;
        lin_next       = lin_reg;
        rin_next       = rin_reg;
        sum_next       = sum_reg;
        damp_next      = damp_reg;
        fbst_next      = fbst_reg;
        slot_next      = slot_reg;
        y_next         = y_reg;
        lres_next      = lres_reg;
        lout_next      = lout_reg;
        rout_next      = rout_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        dl_we    = 1'b0;
        dl_waddr = pos_reg;
        dl_wdata = slot_reg;
        dl_raddr = pos_reg;
        cf_we    = 1'b0;
        cf_waddr = CW'(coef_index);
        cf_wdata = coef_value;

        mac_op.en  = 1'b0;
        mac_op.clr = 1'b0;
        mac_a      = '0;
        mac_b      = '0;

        // Feed FIR products from the previous cycle's reads
        if (fir_vld_reg)
        begin
            mac_op.en = 1'b1;
            mac_a     = cvr_pkg::OPA_W'(signed'(dl_rdata));
            mac_b     = cvr_pkg::OPB_W'(signed'(cf_rdata));
        end

        case (state_reg)
            cvr_pkg::ST_CLEAR:
            begin
                dl_we    = (32'(clr_cnt_reg) < 32'(BUFFER_DEPTH));
                dl_waddr = BW'(clr_cnt_reg);
                dl_wdata = '0;
                cf_we    = (32'(clr_cnt_reg) < 32'(MAX_TAPS));
                cf_waddr = CW'(clr_cnt_reg);
                cf_wdata = '0;
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (32'(clr_cnt_reg) == CLR_N - 1)
                begin
                    state_next = cvr_pkg::ST_IDLE;
                end
            end
            cvr_pkg::ST_IDLE:
            begin
                lin_next = left_in;
                rin_next = right_in;
                lm_next  = len;
                im_next  = len >> 1;
                if (req_fire && req_type)
                begin
                    cf_we = (32'(coef_index) < 32'(MAX_TAPS));
                end
                else if (req_fire)
                begin
                    state_next = cvr_pkg::ST_REDUCE;
                end
            end
            // Bring echo offsets below the buffer depth
            cvr_pkg::ST_REDUCE:
            begin
                if (32'(lm_reg) >= 32'(BUFFER_DEPTH))
                begin
                    lm_next = lm_reg - LW'(BUFFER_DEPTH);
                end
                else if (32'(im_reg) >= 32'(BUFFER_DEPTH))
                begin
                    im_next = im_reg - LW'(BUFFER_DEPTH);
                end
                else
                begin
                    state_next = cvr_pkg::ST_STALE;
                end
            end
            cvr_pkg::ST_STALE:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = cvr_pkg::OPA_W'(signed'(dl_rdata));
                mac_b      = reverb_en_reg ? cvr_pkg::OPB_W'(fb_gain_reg) : '0;
                state_next = cvr_pkg::ST_STALE_W;
            end
            cvr_pkg::ST_STALE_W:
            begin
                state_next = cvr_pkg::ST_SUM;
            end
            cvr_pkg::ST_SUM:
            begin
                sum_next = cvr_pkg::sat24(AW'(lin_reg) + AW'(rin_reg) + AW'(fbst_reg)
                                          + cvr_pkg::rnd(acc, 15));
                state_next = cvr_pkg::ST_DAMP_A;
            end
            cvr_pkg::ST_DAMP_A:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = cvr_pkg::OPA_W'(sum_reg);
                mac_b      = signed'({1'b0, damp_a});
                state_next = cvr_pkg::ST_DAMP_B;
            end
            cvr_pkg::ST_DAMP_B:
            begin
                mac_op.en  = 1'b1;
                mac_a      = cvr_pkg::OPA_W'(damp_reg);
                mac_b      = signed'({1'b0, cvr_pkg::DAMP_ONE - damp_a});
                state_next = cvr_pkg::ST_DAMP_W;
            end
            cvr_pkg::ST_DAMP_W:
            begin
                state_next = cvr_pkg::ST_DSTORE;
            end
            cvr_pkg::ST_DSTORE:
            begin
                damp_next = cvr_pkg::sat24(cvr_pkg::rnd(acc, 15));
                slot_next = cvr_pkg::sat24(cvr_pkg::rnd(acc, 15));
                xi_next   = back(pos_reg, BW'(lm_reg));
                echo_next = '0;
                state_next = reverb_en_reg ? cvr_pkg::ST_ECHO_ADR : cvr_pkg::ST_SLOT_WR;
            end
            // Multitap echoes into the new slot
            cvr_pkg::ST_ECHO_ADR:
            begin
                xi_next    = back(xi_reg, BW'(im_reg));
                dl_raddr   = xi_next;
                state_next = cvr_pkg::ST_ECHO_MUL;
            end
            cvr_pkg::ST_ECHO_MUL:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = (xi_reg == pos_reg) ? cvr_pkg::OPA_W'(slot_reg)
                                                 : cvr_pkg::OPA_W'(signed'(dl_rdata));
                mac_b      = cvr_pkg::OPB_W'(fb_gain_reg);
                state_next = cvr_pkg::ST_ECHO_W;
            end
            cvr_pkg::ST_ECHO_W:
            begin
                state_next = cvr_pkg::ST_ECHO_ADD;
            end
            cvr_pkg::ST_ECHO_ADD:
            begin
                slot_next = cvr_pkg::sat24(AW'(slot_reg) + cvr_pkg::rnd(acc, 15));
                echo_next = echo_reg + JW'(1);
                state_next = (32'(echo_reg) == REVERB_TAPS - 1) ? cvr_pkg::ST_SLOT_WR
                                                                : cvr_pkg::ST_ECHO_ADR;
            end
            // Store the slot and clear the accumulator for the FIR
            cvr_pkg::ST_SLOT_WR:
            begin
                dl_we      = 1'b1;
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                xi_next    = pos_reg;
                tap_next   = '0;
                drain_next = 1'b0;
                state_next = (len == '0) ? cvr_pkg::ST_FIR_DRAIN : cvr_pkg::ST_FIR_RUN;
            end
            cvr_pkg::ST_FIR_RUN:
            begin
                dl_raddr = xi_dec;
                xi_next  = xi_dec;
                tap_next = tap_reg + LW'(1);
                if (tap_reg == len - LW'(1))
                begin
                    state_next = cvr_pkg::ST_FIR_DRAIN;
                end
            end
            cvr_pkg::ST_FIR_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = cvr_pkg::ST_YSET;
                end
            end
            cvr_pkg::ST_YSET:
            begin
                y_next     = cvr_pkg::sat24(cvr_pkg::rnd(acc, 15));
                state_next = cvr_pkg::ST_FB_A;
            end
            // Feedback: fb * y * 0.15
            cvr_pkg::ST_FB_A:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = cvr_pkg::OPA_W'(y_reg);
                mac_b      = cvr_pkg::OPB_W'(fb_gain_reg);
                state_next = cvr_pkg::ST_FB_AW;
            end
            cvr_pkg::ST_FB_AW:
            begin
                state_next = cvr_pkg::ST_FB_B;
            end
            cvr_pkg::ST_FB_B:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = acc[cvr_pkg::OPA_W-1:0];
                mac_b      = cvr_pkg::FB_SCALE;
                state_next = cvr_pkg::ST_FB_BW;
            end
            cvr_pkg::ST_FB_BW:
            begin
                state_next = cvr_pkg::ST_FB_SET;
            end
            cvr_pkg::ST_FB_SET:
            begin
                fbst_next  = cvr_pkg::sat24(cvr_pkg::rnd(acc, 30));
                state_next = cvr_pkg::ST_OUT_L;
            end
            // Output gains
            cvr_pkg::ST_OUT_L:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = cvr_pkg::OPA_W'(y_reg);
                mac_b      = signed'({2'b00, left_gain_reg});
                state_next = cvr_pkg::ST_OUT_LW;
            end
            cvr_pkg::ST_OUT_LW:
            begin
                state_next = cvr_pkg::ST_OUT_R;
            end
            cvr_pkg::ST_OUT_R:
            begin
                lres_next  = cvr_pkg::sat16(cvr_pkg::rnd(acc, 10));
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_a      = cvr_pkg::OPA_W'(y_reg);
                mac_b      = signed'({2'b00, right_gain_reg});
                state_next = cvr_pkg::ST_OUT_RW;
            end
            cvr_pkg::ST_OUT_RW:
            begin
                state_next = cvr_pkg::ST_OUT_DONE;
            end
            // Hand the word to the output register once it is free
            cvr_pkg::ST_OUT_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    lout_next      = lres_reg;
                    rout_next      = cvr_pkg::sat16(cvr_pkg::rnd(acc, 10));
                    rsp_valid_next = 1'b1;
                    pos_next       = (32'(pos_reg) == BUFFER_DEPTH - 1) ? '0
                                                                        : pos_reg + BW'(1);
                    state_next     = cvr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cvr_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fir_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cvr_pkg::ST_FIR_RUN) |-> (tap_reg < len))
        else $error("FIR tap counter ran past tap count");

    a_xi_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cvr_pkg::ST_ECHO_MUL) |-> (32'(xi_reg) < 32'(BUFFER_DEPTH)))
        else $error("echo index outside delay line");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == cvr_pkg::ST_OUT_DONE))
        else $error("result raised outside completion");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> ($past(state_reg) == cvr_pkg::ST_OUT_DONE))
        else $error("write position moved without a result");
`endif

endmodule

// ===== sv/cvr_ram.sv =====
// ----------------------------------------------------------------------------
// cvr_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module cvr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cvr_mac.sv =====
// ----------------------------------------------------------------------------
// cvr_mac
// Shared multiply-accumulate unit: registered product, then accumulate.
// ----------------------------------------------------------------------------
module cvr_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cvr_pkg::mac_op_t                    op,
    input  logic signed [cvr_pkg::OPA_W-1:0]    opa,
    input  logic signed [cvr_pkg::OPB_W-1:0]    opb,
    output logic signed [cvr_pkg::ACC_W-1:0]    acc
);

    logic signed [cvr_pkg::PROD_W-1:0] prod_reg;
    logic                              pv_reg;
    logic                              pclr_reg;
    logic signed [cvr_pkg::ACC_W-1:0]  acc_reg;

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            pclr_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= op.en;
            pclr_reg <= op.clr;
        end
    end

    // Accumulate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= (pclr_reg ? '0 : acc_reg) + cvr_pkg::ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives audio and coefficient words into the convolution reverb core.
// Every accepted audio word is run through a cycle-free fixed-point model
// of the reverb. Each output word is then checked against that model.
// The run covers several register settings, stalls on both sides, and
// a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH      = 32768;
    localparam int TAPS       = 4096;
    localparam int ECHOES     = 5;
    localparam int FB_Q15     = 4915;
    localparam int STALL_MAX  = 100000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic               kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [11:0]        tap;
        logic signed [15:0] coef;
    } req_word_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } out_word_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [cvr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]        cfg_data   = '0;
    logic               req_valid  = 1'b0;
    logic               req_ready;
    logic               req_type   = 1'b0;
    logic signed [15:0] left_in    = '0;
    logic signed [15:0] right_in   = '0;
    logic [11:0]        coef_index = '0;
    logic signed [15:0] coef_value = '0;
    logic               rsp_valid;
    logic               rsp_ready  = 1'b0;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    // Reverb model state
    int  delay_mem [DEPTH];
    int  ir_mem [TAPS];
    int  wr_pos;
    int  damp_acc;
    int  fb_acc;
    int  r_damp  = 25033;
    int  r_fb    = 0;
    int  r_en    = 0;
    int  r_len   = 1024;
    int  r_lgain = 1024;
    int  r_rgain = 1024;

    req_word_t word_q[$];
    req_word_t cur_word;
    out_word_t out_q[$];

    int  idle_pct   = 31;
    bit  hold_req   = 1'b0;
    int  hold_cnt   = 0;
    int  mismatches = 0;
    int  stall_cnt  = 0;

    convolution_reverb_fir_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .left_in    (left_in),
        .right_in   (right_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .left_out   (left_out),
        .right_out  (right_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Round half up, then floor
    function automatic longint round_q(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic int clip24(input longint v);
        return int'(clamp(v, -8388608, 8388607));
    endfunction

    // Apply one word to the reverb model; audio words queue an output word
    function automatic void reverb_apply(input req_word_t w);
        longint    a, sum, acc, gain;
        int        pos, len, span, offs, xi, y;
        out_word_t o;
        if (w.kind)
        begin
            ir_mem[w.tap] = int'(w.coef);
            return;
        end
        pos  = wr_pos;
        len  = (r_len > TAPS) ? TAPS : r_len;
        a    = (r_damp > 32768) ? 32768 : r_damp;
        gain = r_fb;
        sum  = longint'(w.left) + longint'(w.right) + fb_acc;
        if (r_en != 0)
            sum += round_q(gain * delay_mem[pos], 15);
        sum = clip24(sum);
        damp_acc = clip24(round_q(a * sum + (32768 - a) * longint'(damp_acc), 15));
        delay_mem[pos] = damp_acc;
        // add echoes into the fresh slot
        if (r_en != 0)
        begin
            span = len / 2;
            offs = len;
            for (int j = 0; j < ECHOES; j++)
            begin
                offs += span;
                xi = (pos + DEPTH - (offs % DEPTH)) % DEPTH;
                delay_mem[pos] = clip24(longint'(delay_mem[pos])
                                        + round_q(gain * delay_mem[xi], 15));
            end
        end
        // FIR over the earlier samples
        acc = 0;
        xi  = pos;
        for (int j = 0; j < len; j++)
        begin
            xi = (xi == 0) ? DEPTH - 1 : xi - 1;
            acc += longint'(ir_mem[j]) * delay_mem[xi];
        end
        y = clip24(round_q(acc, 15));
        fb_acc = clip24(round_q(gain * y * FB_Q15, 30));
        o.left  = 16'(clamp(round_q(longint'(y) * r_lgain, 10), -32768, 32767));
        o.right = 16'(clamp(round_q(longint'(y) * r_rgain, 10), -32768, 32767));
        out_q.push_back(o);
        wr_pos = (pos + 1) % DEPTH;
    endfunction

    // Sender: present queued words, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                reverb_apply(cur_word);
            if (!req_valid || req_ready)
            begin
                if (word_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_word = word_q.pop_front();
                    req_valid  <= 1'b1;
                    req_type   <= cur_word.kind;
                    left_in    <= cur_word.left;
                    right_in   <= cur_word.right;
                    coef_index <= cur_word.tap;
                    coef_value <= cur_word.coef;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            rsp_ready <= 1'b0;
            hold_cnt  = hold_cnt + 1;
            if (hold_cnt >= HOLD_LEN)
            begin
                hold_req = 1'b0;
                hold_cnt = 0;
            end
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Check output words and watch for a hang
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n)
        begin
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready)
                || (cfg_valid && cfg_ready))
                stall_cnt = 0;
            else
                stall_cnt = stall_cnt + 1;
            if (rsp_valid && rsp_ready)
            begin
                if (out_q.size() == 0)
                begin
                    $error("output word with none expected: left %0d right %0d",
                           left_out, right_out);
                    mismatches++;
                end
                else
                begin
                    e = out_q.pop_front();
                    if (left_out !== e.left)
                    begin
                        $error("left_out: expected %0d, got %0d", e.left, left_out);
                        mismatches++;
                    end
                    if (right_out !== e.right)
                    begin
                        $error("right_out: expected %0d, got %0d", e.right, right_out);
                        mismatches++;
                    end
                end
            end
            if (stall_cnt >= STALL_MAX)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_MAX);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_audio(input logic signed [15:0] l, input logic signed [15:0] r);
        req_word_t w;
        w.kind  = 1'b0;
        w.left  = l;
        w.right = r;
        w.tap   = 12'($urandom);
        w.coef  = 16'($urandom);
        word_q.push_back(w);
    endtask

    task automatic push_coef(input logic [11:0] t, input logic signed [15:0] c);
        req_word_t w;
        w.kind  = 1'b1;
        w.left  = 16'($urandom);
        w.right = 16'($urandom);
        w.tap   = t;
        w.coef  = c;
        word_q.push_back(w);
    endtask

    // Hold until the core has drained and settled; sample between edges
    task automatic wait_drained();
        while (word_q.size() > 0 || req_valid || out_q.size() > 0)
            @(negedge clk);
        repeat (((r_len > TAPS) ? TAPS : r_len) + 80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cvr_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            cvr_pkg::CFG_DAMP_GAIN:  r_damp  = val & 16'hFFFF;
            cvr_pkg::CFG_FB_GAIN:    r_fb    = int'($signed(16'(val)));
            cvr_pkg::CFG_REVERB_EN:  r_en    = val & 1;
            cvr_pkg::CFG_IR_LENGTH:  r_len   = val & 13'h1FFF;
            cvr_pkg::CFG_LEFT_GAIN:  r_lgain = val & 16'hFFFF;
            cvr_pkg::CFG_RIGHT_GAIN: r_rgain = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(input int damp, input int fb, input int en, input int len,
                            input int lg, input int rg);
        write_reg(cvr_pkg::CFG_DAMP_GAIN, damp);
        write_reg(cvr_pkg::CFG_FB_GAIN, fb);
        write_reg(cvr_pkg::CFG_REVERB_EN, en);
        write_reg(cvr_pkg::CFG_IR_LENGTH, len);
        write_reg(cvr_pkg::CFG_LEFT_GAIN, lg);
        write_reg(cvr_pkg::CFG_RIGHT_GAIN, rg);
    endtask

    // Random mix: mostly audio, some loads aimed at the taps in use
    task automatic random_words(input int n);
        int span;
        span = (r_len > TAPS) ? TAPS : ((r_len == 0) ? 1 : r_len);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 25)
                push_coef(($urandom_range(3) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(span - 1)),
                          pick_sample());
            else
                push_audio(pick_sample(), pick_sample());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: load extreme taps, then extreme samples
        push_coef(12'd0, 16'sd32767);
        push_coef(12'd1, -16'sd32768);
        push_coef(12'd4095, 16'sd32767);
        push_coef(12'd2, 16'sd16384);
        push_audio(16'sd32767, 16'sd32767);
        push_audio(-16'sd32768, -16'sd32768);
        push_audio(16'sd0, 16'sd0);
        push_audio(16'sd32767, -16'sd32768);
        push_audio(16'sd1000, -16'sd1);
        wait_drained();

        // full damping weight, strongest positive feedback, echoes on
        set_regs(32768, 32767, 1, 16, 65535, 0);
        push_coef(12'd3, -16'sd20000);
        push_audio(16'sd32767, 16'sd32767);
        push_audio(16'sd12345, -16'sd321);
        push_audio(-16'sd32768, 16'sd0);
        wait_drained();

        // weight too large, strongest negative feedback, no FIR taps
        set_regs(65535, -32768, 1, 0, 1024, 65535);
        push_audio(16'sd32767, 16'sd0);
        push_audio(-16'sd32768, -16'sd32768);
        push_audio(16'sd500, 16'sd500);
        wait_drained();

        // zero weight, single tap, echoes off; no idling for a while
        idle_pct = 0;
        set_regs(0, 12000, 0, 1, 0, 32768);
        random_words(20);
        wait_drained();
        idle_pct = 31;

        // long receiver hold-off so the core backs up
        set_regs(20000, -9000, 1, 24, 2048, 700);
        hold_req = 1'b1;
        random_words(20);
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            set_regs($urandom_range(32768), int'($signed(16'($urandom))),
                     $urandom_range(1), $urandom_range(1, 40),
                     $urandom_range(65535), $urandom_range(4096));
            random_words(20);
            wait_drained();
        end

        // tap counts at and above the table size, a few words only
        set_regs(25033, 4000, 1, 4096, 1024, 1024);
        random_words(3);
        wait_drained();
        set_regs(16000, -3000, 1, 8191, 3000, 1024);
        random_words(3);
        wait_drained();

        // small tap counts again, first with the other registers zero, then with large values
        set_regs(0, 0, 0, 12, 0, 0);
        random_words(8);
        wait_drained();
        set_regs(30000, 20000, 1, 10, 65535, 65535);
        random_words(14);
        wait_drained();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cvr_pkg.sv
sv/cvr_ram.sv
sv/cvr_mac.sv
sv/convolution_reverb_fir_core.sv
bench/testbench.sv
